// File: rtl/fsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_pkg: shared types and helpers for the floored signed divider
// Operand width codes, pipeline payload structs and sign-extension helpers.
// ----------------------------------------------------------------------------
package fsd_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned NumSteps = DataW;

  // Operand width codes; the unused code is handled as 32 bit.
  localparam logic [1:0] ACT_W8  = 2'd0;
  localparam logic [1:0] ACT_W16 = 2'd1;
  localparam logic [1:0] ACT_W32 = 2'd2;

  typedef struct packed {
    logic [1:0] act;
    logic       a_neg;
    logic       b_neg;
    logic       div_zero;
    logic       ovf;
  } fsd_ctl_t;

  // Payload of one restoring step: partial remainder, dividend/quotient
  // shift word and divisor magnitude.
  typedef struct packed {
    fsd_ctl_t         ctl;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] dmag;
  } fsd_div_t;

  // Payload after the floor correction.
  typedef struct packed {
    fsd_ctl_t         ctl;
    logic [DataW-1:0] qval;
    logic [DataW-1:0] rmag;
    logic             rneg;
  } fsd_fix_t;

  function automatic logic [DataW-1:0] sext_act(input logic [DataW-1:0] v,
                                                input logic [1:0] act);
    logic [DataW-1:0] r;
    case (act)
      ACT_W8:  r = {{(DataW-8){v[7]}}, v[7:0]};
      ACT_W16: r = {{(DataW-16){v[15]}}, v[15:0]};
      ACT_W32: r = v;
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic logic [DataW-1:0] min_act(input logic [1:0] act);
    logic [DataW-1:0] r;
    case (act)
      ACT_W8:  r = {{(DataW-7){1'b1}}, 7'd0};
      ACT_W16: r = {{(DataW-15){1'b1}}, 15'd0};
      ACT_W32: r = {1'b1, {(DataW-1){1'b0}}};
      default: r = {1'b1, {(DataW-1){1'b0}}};
    endcase
    return r;
  endfunction

endpackage

// File: rtl/fsd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_in_if: operand channel
// Valid/ready channel carrying the width code and both operands.
// ----------------------------------------------------------------------------
interface fsd_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       action;
  logic signed [fsd_pkg::DataW-1:0] dividend;
  logic signed [fsd_pkg::DataW-1:0] divisor;

  modport source (output valid, action, dividend, divisor, input ready);
  modport sink   (input valid, action, dividend, divisor, output ready);
endinterface

// File: rtl/fsd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_out_if: result channel
// Valid/ready channel carrying quotient, remainder and the two flags.
// ----------------------------------------------------------------------------
interface fsd_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [fsd_pkg::DataW-1:0] quotient;
  logic signed [fsd_pkg::DataW-1:0] remainder;
  logic                             divide_by_zero;
  logic                             overflow;

  modport source (output valid, quotient, remainder, divide_by_zero, overflow,
                  input ready);
  modport sink   (input valid, quotient, remainder, divide_by_zero, overflow,
                  output ready);
endinterface

// File: rtl/fsd_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_prep: operand preparation stage
// Sign-extends the operands, takes magnitudes and detects special cases.
// ----------------------------------------------------------------------------
module fsd_prep (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [1:0]                 action_i,
  input  logic [fsd_pkg::DataW-1:0]  dividend_i,
  input  logic [fsd_pkg::DataW-1:0]  divisor_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output fsd_pkg::fsd_div_t          data_o
);

  logic [fsd_pkg::DataW-1:0] a_ext, b_ext;
  fsd_pkg::fsd_div_t         data_d, data_q;
  logic                      valid_q;

  assign a_ext = fsd_pkg::sext_act(dividend_i, action_i);
  assign b_ext = fsd_pkg::sext_act(divisor_i, action_i);

  always_comb begin
    data_d.ctl.act      = action_i;
    data_d.ctl.a_neg    = a_ext[fsd_pkg::DataW-1];
    data_d.ctl.b_neg    = b_ext[fsd_pkg::DataW-1];
    data_d.ctl.div_zero = (b_ext == '0);
    data_d.ctl.ovf      = (b_ext == '1) && (a_ext == fsd_pkg::min_act(action_i));
    data_d.rem          = '0;
    data_d.quo          = a_ext[fsd_pkg::DataW-1] ? -a_ext : a_ext;
    data_d.dmag         = b_ext[fsd_pkg::DataW-1] ? -b_ext : b_ext;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/fsd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_step: one restoring division step
// Produces one quotient bit per stage with a single trial subtraction.
// ----------------------------------------------------------------------------
module fsd_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  fsd_pkg::fsd_div_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output fsd_pkg::fsd_div_t data_o
);

  logic [fsd_pkg::DataW:0] shifted, trial;
  fsd_pkg::fsd_div_t       data_d, data_q;
  logic                    valid_q;

  assign shifted = {data_i.rem, data_i.quo[fsd_pkg::DataW-1]};
  assign trial   = shifted - {1'b0, data_i.dmag};

  always_comb begin
    data_d      = data_i;
    // keep the trial difference when it did not go negative
    data_d.rem  = trial[fsd_pkg::DataW] ? shifted[fsd_pkg::DataW-1:0]
                                        : trial[fsd_pkg::DataW-1:0];
    data_d.quo  = {data_i.quo[fsd_pkg::DataW-2:0], ~trial[fsd_pkg::DataW]};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/fsd_fix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_fix: floor correction stage
// Applies operand signs and moves a truncated result to floored form.
// ----------------------------------------------------------------------------
module fsd_fix (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  fsd_pkg::fsd_div_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output fsd_pkg::fsd_fix_t data_o
);

  logic              sign_diff, adjust;
  fsd_pkg::fsd_fix_t data_d, data_q;
  logic              valid_q;

  assign sign_diff = data_i.ctl.a_neg ^ data_i.ctl.b_neg;
  assign adjust    = sign_diff && (data_i.rem != '0) && !data_i.ctl.div_zero;

  always_comb begin
    data_d.ctl = data_i.ctl;
    // floored quotient: -q - 1 equals ~q when a nonzero remainder is moved
    if (!sign_diff) begin
      data_d.qval = data_i.quo;
    end else if (adjust) begin
      data_d.qval = ~data_i.quo;
    end else begin
      data_d.qval = -data_i.quo;
    end
    data_d.rmag = adjust ? (data_i.dmag - data_i.rem) : data_i.rem;
    data_d.rneg = adjust ? data_i.ctl.b_neg : data_i.ctl.a_neg;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/fsd_fin.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_fin: result formatting and output register
// Signs the remainder, wraps both results to the width and sets flags.
// ----------------------------------------------------------------------------
module fsd_fin (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  fsd_pkg::fsd_fix_t         data_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [fsd_pkg::DataW-1:0] quotient_o,
  output logic [fsd_pkg::DataW-1:0] remainder_o,
  output logic                      divide_by_zero_o,
  output logic                      overflow_o
);

  logic [fsd_pkg::DataW-1:0] rem_signed;
  logic [fsd_pkg::DataW-1:0] quo_d, quo_q, rem_d, rem_q;
  logic                      dz_q, ovf_q, valid_q;

  assign rem_signed = data_i.rneg ? -data_i.rmag : data_i.rmag;
  assign rem_d      = fsd_pkg::sext_act(rem_signed, data_i.ctl.act);
  assign quo_d      = data_i.ctl.div_zero ? '1
                                          : fsd_pkg::sext_act(data_i.qval, data_i.ctl.act);

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      dz_q  <= data_i.ctl.div_zero;
      ovf_q <= data_i.ctl.ovf && !data_i.ctl.div_zero;
    end
  end

  assign valid_o          = valid_q;
  assign quotient_o       = quo_q;
  assign remainder_o      = rem_q;
  assign divide_by_zero_o = dz_q;
  assign overflow_o       = ovf_q;

endmodule

// File: rtl/floored_signed_divider_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floored_signed_divider_top: pipelined floored signed divider
// 8/16/32-bit signed division rounding toward negative infinity; the
// remainder takes the sign of the divisor. Zero divisor and overflow flagged.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                      handshake
//   in_i     in   action, dividend, divisor                    valid/ready
//   out_o    out  quotient, remainder, divide_by_zero, overflow valid/ready
//
// Throughput: one transfer per cycle in each direction while out_o is not stalled.
// Pipeline: 1 prep stage + 32 restoring steps (one quotient bit
//   per stage, one 33-bit subtract each) + floor fix stage + output register.
// Reset: clears only the stage valid bits; payload registers are not reset.
// Stalls: every stage holds while it is full and its successor is full and
//   stalled; empty stages keep filling, so input transfers continue while a
//   result waits at the output until the whole pipeline is full.
// ----------------------------------------------------------------------------
module floored_signed_divider_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  fsd_in_if.sink    in_i,
  fsd_out_if.source out_o
);

  // Stage k of the step chain reads step_data[k] and writes step_data[k+1].
  logic                 step_valid [fsd_pkg::NumSteps+1];
  logic                 step_ready [fsd_pkg::NumSteps+1];
  fsd_pkg::fsd_div_t    step_data  [fsd_pkg::NumSteps+1];

  logic                 fix_valid, fix_ready;
  fsd_pkg::fsd_fix_t    fix_data;

  logic [fsd_pkg::DataW-1:0] quo_w, rem_w;
  logic                      dz_w, ovf_w, out_valid_w;

  // Sign-extend operands, take magnitudes, flag zero divisor and overflow.
  fsd_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_i.valid),
    .ready_o    (in_i.ready),
    .action_i   (in_i.action),
    .dividend_i (in_i.dividend),
    .divisor_i  (in_i.divisor),
    .valid_o    (step_valid[0]),
    .ready_i    (step_ready[0]),
    .data_o     (step_data[0])
  );

  // Unsigned restoring division on magnitudes, one quotient bit per stage.
  for (genvar k = 0; k < fsd_pkg::NumSteps; k++) begin : g_step
    fsd_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (step_valid[k]),
      .ready_o (step_ready[k]),
      .data_i  (step_data[k]),
      .valid_o (step_valid[k+1]),
      .ready_i (step_ready[k+1]),
      .data_o  (step_data[k+1])
    );
  end

  // Convert the truncated magnitude result to floored signed form.
  fsd_fix u_fix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (step_valid[fsd_pkg::NumSteps]),
    .ready_o (step_ready[fsd_pkg::NumSteps]),
    .data_i  (step_data[fsd_pkg::NumSteps]),
    .valid_o (fix_valid),
    .ready_i (fix_ready),
    .data_o  (fix_data)
  );

  // Sign the remainder, wrap to the selected width, override on zero divisor.
  fsd_fin u_fin (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (fix_valid),
    .ready_o          (fix_ready),
    .data_i           (fix_data),
    .valid_o          (out_valid_w),
    .ready_i          (out_o.ready),
    .quotient_o       (quo_w),
    .remainder_o      (rem_w),
    .divide_by_zero_o (dz_w),
    .overflow_o       (ovf_w)
  );

  assign out_o.valid          = out_valid_w;
  assign out_o.quotient       = quo_w;
  assign out_o.remainder      = rem_w;
  assign out_o.divide_by_zero = dz_w;
  assign out_o.overflow       = ovf_w;

  // The two special cases are exclusive.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.divide_by_zero && out_o.overflow))
    else $error("divide_by_zero and overflow both set");

  // A zero divisor always returns an all-ones quotient.
  a_dz_quotient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.divide_by_zero) |-> (out_o.quotient == '1))
    else $error("zero divisor result without all-ones quotient");

  // Overflow always leaves a zero remainder.
  a_ovf_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.overflow) |-> (out_o.remainder == '0))
    else $error("overflow result with nonzero remainder");

  // Back-pressure at the input can only come from a stalled, full output.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled without a stalled output");

endmodule
